>>> design/vertex_normal_accumulator_top_defines.svh
// Assertion helpers for the vertex normal accumulator.
`ifndef VERTEX_NORMAL_ACCUMULATOR_TOP_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VNA_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication.
`define VNA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define VNA_ASSERT_IMPL(label, pre, post)
`define VNA_ASSERT_NEXT(label, pre, post)

`endif

`endif

>>> design/vna_pkg.sv
`timescale 1ns / 1ps

package vna_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FACE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX  = 2'd1;
    localparam logic [1:0] ST_DEGENERATE = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    // magnitudes: cross product needs 35 bits signed, sums are SUM_WIDTH bits (24 by default)
    localparam int MAG_W   = 35;
    localparam int POS_W   = 16;
    localparam int NRM_W   = 16;
    localparam int CRN_W   = 13;
    localparam int PROD_W  = 50;
    localparam int ROOT_W  = 25;
    localparam int QUO_W   = 15;
    localparam logic [QUO_W-1:0] UNIT_ONE = 15'd16384;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [NRM_W-1:0] t_nrm;
    typedef logic signed [MAG_W-1:0] t_vec;
    typedef logic [MAG_W-1:0]        t_mag;

endpackage

>>> design/vertex_normal_accumulator_top.sv
`timescale 1ns / 1ps
// Smooth vertex normal builder. Every request gives one response. Load and clear
// requests, and requests with a bad vertex number, go straight from idle to the
// finishing state. Reads and faces take longer: one shared 25x25 multiplier
// forms the cross product and the squares, the normalising shift moves one bit a
// cycle, the square root yields one bit a cycle and the three components are
// divided one after another, one quotient bit a cycle. The sum update for a face
// is three read-modify-writes, each a read state and a write state, on the sum
// memory. The block takes a new request only once the previous one is finished,
// and a response waiting in the output register holds it up until it is taken.
// The memories need no clearing pass after reset.
`include "vertex_normal_accumulator_top_defines.svh"

module vertex_normal_accumulator_top
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int SUM_WIDTH    = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_operation,
    input  logic signed [POS_W-1:0] i_position_x,
    input  logic signed [POS_W-1:0] i_position_y,
    input  logic signed [POS_W-1:0] i_position_z,
    input  logic [CRN_W-1:0]        i_corner_a,
    input  logic [CRN_W-1:0]        i_corner_b,
    input  logic [CRN_W-1:0]        i_corner_c,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic signed [NRM_W-1:0] o_normal_x,
    output logic signed [NRM_W-1:0] o_normal_y,
    output logic signed [NRM_W-1:0] o_normal_z,
    output logic [CRN_W-1:0]        o_vertices_held
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int TW = $clog2(MAX_VERTICES + 1);
    localparam int SW = SUM_WIDTH;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRD  = 4'd1;
    localparam logic [3:0] S_EDGE = 4'd2;
    localparam logic [3:0] S_XMUL = 4'd3;
    localparam logic [3:0] S_SRD  = 4'd4;
    localparam logic [3:0] S_ABS  = 4'd5;
    localparam logic [3:0] S_NORM = 4'd6;
    localparam logic [3:0] S_SQ   = 4'd7;
    localparam logic [3:0] S_SQRT = 4'd8;
    localparam logic [3:0] S_DIVI = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_RMWR = 4'd11;
    localparam logic [3:0] S_RMWW = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0]        r_state;
    logic [TW-1:0]     r_total;
    logic [1:0]        r_op;
    logic [1:0]        r_status;
    logic [4:0]        r_cnt;
    logic [1:0]        r_comp;
    logic [AW-1:0]     r_idx [3];
    t_pos              r_pa [3];
    t_pos              r_pb [3];
    t_pos              r_pc [3];
    logic signed [16:0] r_e1 [3];
    logic signed [16:0] r_e2 [3];
    t_vec              r_vec [3];
    t_mag              r_mag [3];
    logic [2:0]        r_neg;
    logic signed [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_sq;
    logic [PROD_W:0]   r_res;
    logic [ROOT_W-1:0] r_len;
    logic [ROOT_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_nlo;
    logic [QUO_W-1:0]  r_quo;
    t_nrm              r_n [3];
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    t_nrm              r_out_n [3];
    logic [TW-1:0]     r_out_total;

    logic              in_accept;
    logic              full;
    logic              ok_a;
    logic              ok_b;
    logic              ok_c;
    logic              out_free;

    logic              pos_we;
    logic [AW-1:0]     pos_waddr;
    logic [3*POS_W-1:0] pos_wdata;
    logic              pos_re;
    logic [AW-1:0]     pos_raddr;
    logic [3*POS_W-1:0] pos_rdata;
    t_pos              pos_rd [3];

    logic              sum_we;
    logic [AW-1:0]     sum_waddr;
    logic [3*SW-1:0]   sum_wdata;
    logic              sum_re;
    logic [AW-1:0]     sum_raddr;
    logic [3*SW-1:0]   sum_rdata;
    logic signed [SW-1:0] sum_rd [3];
    logic signed [SW:0]   sum_ext [3];
    logic [SW-1:0]        sum_sat [3];

    logic signed [ROOT_W-1:0] mul_a;
    logic signed [ROOT_W-1:0] mul_b;

    logic              hi_any;
    logic              b23_any;
    logic [PROD_W:0]   root_bit;
    logic [PROD_W:0]   root_try;
    logic [38:0]       div_num;
    logic [ROOT_W:0]   div_try;
    logic              div_bit;
    logic [QUO_W-1:0]  div_q;
    logic [QUO_W-1:0]  div_qc;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign full = (32'(r_total) >= MAX_VERTICES);
    assign ok_a = (i_corner_a != '0) && (32'(i_corner_a) <= 32'(r_total));
    assign ok_b = (i_corner_b != '0) && (32'(i_corner_b) <= 32'(r_total));
    assign ok_c = (i_corner_c != '0) && (32'(i_corner_c) <= 32'(r_total));
    assign out_free = !r_out_valid || i_out_ready;

    // memories
    assign pos_we    = in_accept && (i_operation == OP_LOAD) && !full;
    assign pos_waddr = AW'(r_total);
    assign pos_wdata = {i_position_z, i_position_y, i_position_x};
    assign pos_re    = (r_state == S_PRD) && (r_cnt < 5'd3);
    assign pos_raddr = r_idx[r_cnt[1:0]];
    assign pos_rd[0] = pos_rdata[POS_W-1:0];
    assign pos_rd[1] = pos_rdata[2*POS_W-1:POS_W];
    assign pos_rd[2] = pos_rdata[3*POS_W-1:2*POS_W];

    vna_ram #(.WIDTH(3*POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    assign sum_rd[0] = sum_rdata[SW-1:0];
    assign sum_rd[1] = sum_rdata[2*SW-1:SW];
    assign sum_rd[2] = sum_rdata[3*SW-1:2*SW];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_ext[i] = (SW+1)'(sum_rd[i]) + (SW+1)'(r_n[i]);
            if (sum_ext[i][SW] != sum_ext[i][SW-1]) begin
                sum_sat[i] = sum_ext[i][SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end else begin
                sum_sat[i] = sum_ext[i][SW-1:0];
            end
        end
    end

    always_comb begin
        sum_we    = 1'b0;
        sum_waddr = AW'(r_total);
        sum_wdata = '0;
        sum_re    = 1'b0;
        sum_raddr = r_idx[r_comp];
        if (pos_we) begin
            sum_we = 1'b1;
        end else if (r_state == S_RMWW) begin
            sum_we    = 1'b1;
            sum_waddr = r_idx[r_comp];
            sum_wdata = {sum_sat[2], sum_sat[1], sum_sat[0]};
        end
        if (in_accept && (i_operation == OP_READ)) begin
            sum_re    = 1'b1;
            sum_raddr = AW'(i_corner_a - 13'd1);
        end else if (r_state == S_RMWR) begin
            sum_re = 1'b1;
        end
    end

    vna_ram #(.WIDTH(3*SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_XMUL) begin
            case (r_cnt)
                5'd0: begin mul_a = ROOT_W'(r_e1[1]); mul_b = ROOT_W'(r_e2[2]); end
                5'd1: begin mul_a = ROOT_W'(r_e1[2]); mul_b = ROOT_W'(r_e2[1]); end
                5'd2: begin mul_a = ROOT_W'(r_e1[2]); mul_b = ROOT_W'(r_e2[0]); end
                5'd3: begin mul_a = ROOT_W'(r_e1[0]); mul_b = ROOT_W'(r_e2[2]); end
                5'd4: begin mul_a = ROOT_W'(r_e1[0]); mul_b = ROOT_W'(r_e2[1]); end
                5'd5: begin mul_a = ROOT_W'(r_e1[1]); mul_b = ROOT_W'(r_e2[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if ((r_state == S_SQ) && (r_cnt < 5'd3)) begin
            mul_a = {1'b0, r_mag[r_cnt[1:0]][23:0]};
            mul_b = {1'b0, r_mag[r_cnt[1:0]][23:0]};
        end
    end

    assign hi_any  = (|r_mag[0][MAG_W-1:24]) | (|r_mag[1][MAG_W-1:24])
                   | (|r_mag[2][MAG_W-1:24]);
    assign b23_any = r_mag[0][23] | r_mag[1][23] | r_mag[2][23];

    assign root_bit = (PROD_W+1)'(1) << {r_cnt, 1'b0};
    assign root_try = r_res + root_bit;

    // numerator mag * 2^14 + len / 2, quotient fits 15 bits
    assign div_num = {r_mag[r_comp][23:0], 14'd0} + 39'(r_len >> 1);
    assign div_try = {r_rem, r_nlo[QUO_W-1]};
    assign div_bit = (div_try >= {1'b0, r_len});
    assign div_q   = {r_quo[QUO_W-2:0], div_bit};
    assign div_qc  = (div_q > UNIT_ONE) ? UNIT_ONE : div_q;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_op     <= i_operation;
                        r_status <= ST_OK;
                        r_n[0]   <= '0;
                        r_n[1]   <= '0;
                        r_n[2]   <= '0;
                        r_cnt    <= '0;
                        r_comp   <= '0;
                        r_idx[0] <= AW'(i_corner_a - 13'd1);
                        r_idx[1] <= AW'(i_corner_b - 13'd1);
                        r_idx[2] <= AW'(i_corner_c - 13'd1);
                        r_state  <= S_FIN;
                        case (i_operation)
                            OP_LOAD: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_total <= r_total + 1'b1;
                                end
                            end
                            OP_FACE: begin
                                if (ok_a && ok_b && ok_c) begin
                                    r_state <= S_PRD;
                                end else begin
                                    r_status <= ST_BAD_INDEX;
                                end
                            end
                            OP_READ: begin
                                if (ok_a) begin
                                    r_state <= S_SRD;
                                end else begin
                                    r_status <= ST_BAD_INDEX;
                                end
                            end
                            default: begin
                                r_total <= '0;
                            end
                        endcase
                    end
                end
                S_PRD: begin
                    if (r_cnt != 5'd0) begin
                        for (int i = 0; i < 3; i++) begin
                            case (r_cnt)
                                5'd1:    r_pa[i] <= pos_rd[i];
                                5'd2:    r_pb[i] <= pos_rd[i];
                                default: r_pc[i] <= pos_rd[i];
                            endcase
                        end
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd3) begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= 17'(r_pb[i]) - 17'(r_pa[i]);
                        r_e2[i] <= 17'(r_pc[i]) - 17'(r_pa[i]);
                    end
                    r_cnt   <= '0;
                    r_state <= S_XMUL;
                end
                S_XMUL: begin
                    // product of the previous count lands now
                    if (r_cnt != 5'd0) begin
                        if (r_cnt[0]) begin
                            r_vec[r_cnt[2:1]] <= MAG_W'(r_prod);
                        end else begin
                            r_vec[r_cnt[2:1] - 2'd1] <= r_vec[r_cnt[2:1] - 2'd1]
                                                      - MAG_W'(r_prod);
                        end
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd6) begin
                        r_state <= S_ABS;
                    end
                end
                S_SRD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_vec[i] <= MAG_W'(sum_rd[i]);
                    end
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_vec[i][MAG_W-1] ? t_mag'(-r_vec[i]) : t_mag'(r_vec[i]);
                        r_neg[i] <= r_vec[i][MAG_W-1];
                    end
                    if ((r_vec[0] == '0) && (r_vec[1] == '0) && (r_vec[2] == '0)) begin
                        if (r_op == OP_FACE) begin
                            r_status <= ST_DEGENERATE;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (hi_any) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (!b23_any) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_sq    <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt != 5'd0) begin
                        r_sq <= r_sq + PROD_W'(unsigned'(r_prod));
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd3) begin
                        r_cnt   <= 5'd24;
                        r_res   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if ((PROD_W+1)'(r_sq) >= root_try) begin
                        r_sq  <= PROD_W'((PROD_W+1)'(r_sq) - root_try);
                        r_res <= (r_res >> 1) + root_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    if (r_comp == 2'd0) begin
                        r_len <= r_res[ROOT_W-1:0];
                    end
                    r_state <= (r_comp == 2'd0) ? S_DIVI : S_DIV;
                    if (r_comp != 2'd0 || r_len == r_res[ROOT_W-1:0]) begin
                        r_rem   <= ROOT_W'(div_num >> QUO_W);
                        r_nlo   <= div_num[QUO_W-1:0];
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_bit ? ROOT_W'(div_try - {1'b0, r_len}) : ROOT_W'(div_try);
                    r_nlo <= r_nlo << 1;
                    r_quo <= div_q;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(QUO_W - 1)) begin
                        r_n[r_comp] <= r_neg[r_comp] ? -t_nrm'(div_qc) : t_nrm'(div_qc);
                        if (r_comp == 2'd2) begin
                            r_comp  <= '0;
                            r_state <= (r_op == OP_FACE) ? S_RMWR : S_FIN;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_DIVI;
                        end
                    end
                end
                S_RMWR: begin
                    r_state <= S_RMWW;
                end
                S_RMWW: begin
                    if (r_comp == 2'd2) begin
                        r_state <= S_FIN;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_RMWR;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out_status <= r_status;
            r_out_n[0]   <= r_n[0];
            r_out_n[1]   <= r_n[1];
            r_out_n[2]   <= r_n[2];
            r_out_total  <= r_total;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_normal_x      = r_out_n[0];
    assign o_normal_y      = r_out_n[1];
    assign o_normal_z      = r_out_n[2];
    assign o_vertices_held = CRN_W'(r_total == r_out_total ? r_out_total : r_out_total);

    `VNA_ASSERT_NEXT(a_busy_after_accept, in_accept, !o_in_ready)
    `VNA_ASSERT_NEXT(a_load_counts, in_accept && (i_operation == OP_LOAD) && !full, r_total == $past(r_total) + 1'b1)
    `VNA_ASSERT_NEXT(a_finish_shows, (r_state == S_FIN) && out_free, o_out_valid)
    `VNA_ASSERT_IMPL(a_unit_range, o_out_valid, (o_normal_x <= 16'sd16384) && (o_normal_x >= -16'sd16384) && (o_normal_y <= 16'sd16384) && (o_normal_y >= -16'sd16384))

endmodule

>>> design/vna_ram.sv
`timescale 1ns / 1ps

module vna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
